[design/lpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefix deframer package
// Shared types and constants for the deframer parser and its top level.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam int unsigned LEN_W = 30;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned HDR_W = 32;
  localparam int unsigned CNT_W = 3;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(1024 * 1024);
  localparam logic [1:0] HDR_LEN_MASK = 2'h3;

  localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_HEADER = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic              eom;
    logic [LEN_W-1:0]  len;
  } result_t;

endpackage

[design/length_prefix_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefix deframer
// A result enters the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the output register is not stalled.
// A stalled result holds the output register; a new byte is taken once it drains.
// Reset clears the parse state to expecting a header and sets the maximum
// length register to 1048576.
// ----------------------------------------------------------------------------
module length_prefix_deframer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lpd_pkg::BYTE_W-1:0]   rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lpd_pkg::KIND_W-1:0]   result_kind,
  output logic [lpd_pkg::BYTE_W-1:0]   payload_byte,
  output logic                         end_of_message,
  output logic [lpd_pkg::LEN_W-1:0]    message_length,
  input  logic                         cfg_write_enable,
  input  logic [lpd_pkg::LEN_W-1:0]    cfg_write_data
);

  logic [lpd_pkg::LEN_W-1:0] max_len;
  logic                      accept;
  lpd_pkg::result_t          result;

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= lpd_pkg::MAX_LEN_RESET;
    end else if (cfg_write_enable) begin
      max_len <= cfg_write_data;
    end
  end

  lpd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .max_len (max_len),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= result.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && result.valid) begin
      result_kind <= result.kind;
      payload_byte <= result.data;
      end_of_message <= result.eom;
      message_length <= result.len;
    end
  end

  // A byte is never taken while a stalled result sits in the output register.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != lpd_pkg::KIND_BYTE |-> payload_byte == '0)
    else $error("non-byte result carries payload data");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == lpd_pkg::KIND_EMPTY |-> end_of_message && message_length == '0)
    else $error("empty message result malformed");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == lpd_pkg::KIND_ERROR |-> !end_of_message
      && message_length > $past(max_len))
    else $error("length error result malformed");

endmodule

[design/lpd_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefix deframer parser
// Header assembly, length check and payload counting, one byte per transfer.
// ----------------------------------------------------------------------------
module lpd_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [lpd_pkg::BYTE_W-1:0]   rx_byte,
  input  logic [lpd_pkg::LEN_W-1:0]    max_len,
  output lpd_pkg::result_t             result
);

  lpd_pkg::phase_t phase, phase_next;
  logic [lpd_pkg::CNT_W-1:0] hdr_total, hdr_total_next;
  logic [lpd_pkg::CNT_W-1:0] hdr_seen, hdr_seen_next;
  logic [lpd_pkg::HDR_W-1:0] header_value, header_value_next;
  logic [lpd_pkg::LEN_W-1:0] remaining, remaining_next;

  logic [lpd_pkg::HDR_W-1:0] hv_merged;
  logic [lpd_pkg::HDR_W-1:0] hv_first;
  logic [lpd_pkg::CNT_W-1:0] seen_inc;
  logic [lpd_pkg::LEN_W-1:0] new_len;
  logic [lpd_pkg::LEN_W-1:0] cur_len;
  logic                      hdr_done;
  logic                      too_long;
  logic                      is_empty;
  logic                      last;

  always_comb begin
    case (hdr_seen[1:0])
      2'd0: hv_merged = header_value | {24'b0, rx_byte};
      2'd1: hv_merged = header_value | {16'b0, rx_byte, 8'b0};
      2'd2: hv_merged = header_value | {8'b0, rx_byte, 16'b0};
      default: hv_merged = header_value | {rx_byte, 24'b0};
    endcase
  end

  assign hv_first = {24'b0, rx_byte};
  assign seen_inc = hdr_seen + 3'd1;
  assign cur_len = header_value[lpd_pkg::HDR_W-1:2];
  assign new_len = (phase == lpd_pkg::PH_HEADER) ? hv_merged[lpd_pkg::HDR_W-1:2]
                                                 : hv_first[lpd_pkg::HDR_W-1:2];
  assign too_long = new_len > max_len;
  assign is_empty = new_len == '0;
  assign last = remaining <= lpd_pkg::LEN_W'(1);

  always_comb begin
    case (phase)
      lpd_pkg::PH_PAYLOAD: hdr_done = 1'b0;
      lpd_pkg::PH_HEADER: hdr_done = seen_inc >= hdr_total;
      default: hdr_done = (rx_byte[1:0] & lpd_pkg::HDR_LEN_MASK) == 2'd0;
    endcase
  end

  always_comb begin
    phase_next = phase;
    hdr_total_next = hdr_total;
    hdr_seen_next = hdr_seen;
    header_value_next = header_value;
    remaining_next = remaining;
    case (phase)
      lpd_pkg::PH_PAYLOAD: begin
        if (last) begin
          remaining_next = '0;
          phase_next = lpd_pkg::PH_FIRST;
        end else begin
          remaining_next = remaining - lpd_pkg::LEN_W'(1);
        end
      end
      lpd_pkg::PH_HEADER: begin
        header_value_next = hv_merged;
        hdr_seen_next = seen_inc;
      end
      default: begin
        header_value_next = hv_first;
        hdr_total_next = {1'b0, rx_byte[1:0] & lpd_pkg::HDR_LEN_MASK} + 3'd1;
        hdr_seen_next = 3'd1;
        phase_next = lpd_pkg::PH_HEADER;
      end
    endcase
    if (hdr_done) begin
      if (too_long || is_empty) begin
        phase_next = lpd_pkg::PH_FIRST;
      end else begin
        remaining_next = new_len;
        phase_next = lpd_pkg::PH_PAYLOAD;
      end
    end
  end

  always_comb begin
    result = '0;
    if (accept) begin
      if (phase == lpd_pkg::PH_PAYLOAD) begin
        result.valid = 1'b1;
        result.kind = lpd_pkg::KIND_BYTE;
        result.data = rx_byte;
        result.eom = last;
        result.len = cur_len;
      end else if (hdr_done) begin
        if (too_long) begin
          result.valid = 1'b1;
          result.kind = lpd_pkg::KIND_ERROR;
          result.len = new_len;
        end else if (is_empty) begin
          result.valid = 1'b1;
          result.kind = lpd_pkg::KIND_EMPTY;
          result.eom = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= lpd_pkg::PH_FIRST;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hdr_total <= hdr_total_next;
      hdr_seen <= hdr_seen_next;
      header_value <= header_value_next;
      remaining <= remaining_next;
    end
  end

endmodule
